/* hdl/sfbs_pkg.sv */
// Shared types and constants for the screen fade blend stepper.
package sfbs_pkg;

  localparam int LEVEL_BITS   = 9;
  localparam int STEPS_BITS   = 8;
  localparam int TILE_BITS    = 8;
  localparam int OUT_LVL_BITS = 9;
  localparam int CMD_BITS     = 3;
  localparam int NUM_CH       = 3;
  localparam int CH_BITS      = 2;
  localparam int BIT_CNT_W    = $clog2(LEVEL_BITS);

  localparam logic [LEVEL_BITS-1:0] NEUTRAL_LEVEL = LEVEL_BITS'(9'h100);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_SAVE = 3'd1,
    CMD_SET      = 3'd2,
    CMD_RESTORE  = 3'd3,
    CMD_RESET    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               ld_tgt;
    logic               save;
    logic               restore;
    logic               clr;
    logic               snap;
    logic               div_start;
    logic               div_step;
    logic               commit;
    logic               dec_steps;
    logic               out_load;
    logic [CH_BITS-1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/sfbs_ctrl.sv */
// Sequencer that decodes commands and walks each frame tick with steps left through the three channel divisions.
module sfbs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [sfbs_pkg::CMD_BITS-1:0]    cmd_i,
  input  sfbs_pkg::dp_status_t             status_i,
  output logic                             in_stall_o,
  output sfbs_pkg::dp_cmd_t                cmd_o
);
  import sfbs_pkg::*;

  state_e               state_q, state_d;
  logic [CH_BITS-1:0]   ch_q, ch_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    bit_d      = bit_q;
    cmd_o      = '0;
    cmd_o.ch   = ch_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_TICK: begin
              if (status_i.steps_zero) begin
                cmd_o.snap = 1'b1;
                state_d    = ST_FINISH;
              end else begin
                ch_d    = '0;
                state_d = ST_START;
              end
            end
            CMD_SET_SAVE: begin
              cmd_o.ld_tgt = 1'b1;
              cmd_o.save   = 1'b1;
            end
            CMD_SET:     cmd_o.ld_tgt  = 1'b1;
            CMD_RESTORE: cmd_o.restore = 1'b1;
            CMD_RESET:   cmd_o.clr     = 1'b1;
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        bit_d           = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        bit_d          = bit_q + 1'b1;
        if (bit_q == BIT_CNT_W'(LEVEL_BITS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (ch_q == CH_BITS'(NUM_CH - 1)) begin
          cmd_o.dec_steps = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_START;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/sfbs_datapath.sv */
// Level registers, shared serial divider and blend tile output register.
module sfbs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sfbs_pkg::dp_cmd_t                   cmd_i,
  output sfbs_pkg::dp_status_t                status_o,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_red_i,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_green_i,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_blue_i,
  input  logic [sfbs_pkg::STEPS_BITS-1:0]     steps_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                draw_o,
  output logic                                subtractive_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_red_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_green_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_blue_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_red_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_green_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_blue_o
);
  import sfbs_pkg::*;

  logic [LEVEL_BITS-1:0] cur_q [NUM_CH];
  logic [LEVEL_BITS-1:0] tgt_q [NUM_CH];
  logic [LEVEL_BITS-1:0] sav_q [NUM_CH];
  logic [LEVEL_BITS-1:0] new_lvl [NUM_CH];
  logic [STEPS_BITS-1:0] steps_q;

  // Divider: magnitude shifts out of quo_q while quotient bits shift in.
  logic [LEVEL_BITS-1:0] quo_q;
  logic [STEPS_BITS-1:0] rem_q;
  logic                  neg_q;

  logic signed [LEVEL_BITS:0] diff;
  logic [LEVEL_BITS-1:0]      mag;
  logic [STEPS_BITS:0]        rem_sh;
  logic                       fits;
  logic [STEPS_BITS:0]        rem_sub;
  logic [LEVEL_BITS-1:0]      delta;

  logic                  draw_c, sub_c;
  logic [TILE_BITS-1:0]  tile_c [NUM_CH];
  logic                  out_valid_q;
  logic                  draw_q, sub_q;
  logic [TILE_BITS-1:0]  tile_q [NUM_CH];
  logic [OUT_LVL_BITS-1:0] lvl_q [NUM_CH];

  assign new_lvl[0] = new_red_i;
  assign new_lvl[1] = new_green_i;
  assign new_lvl[2] = new_blue_i;

  assign diff    = $signed({1'b0, tgt_q[cmd_i.ch]}) - $signed({1'b0, cur_q[cmd_i.ch]});
  assign mag     = diff[LEVEL_BITS] ? LEVEL_BITS'(-diff) : diff[LEVEL_BITS-1:0];
  assign rem_sh  = {rem_q, quo_q[LEVEL_BITS-1]};
  assign fits    = rem_sh >= {1'b0, steps_q};
  assign rem_sub = rem_sh - {1'b0, steps_q};
  assign delta   = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cur_q[c] <= '0;
        tgt_q[c] <= '0;
        sav_q[c] <= '0;
      end
      steps_q <= '0;
    end else begin
      if (cmd_i.ld_tgt) begin
        for (int c = 0; c < NUM_CH; c++) tgt_q[c] <= new_lvl[c];
        steps_q <= steps_i;
      end
      if (cmd_i.save) begin
        for (int c = 0; c < NUM_CH; c++) sav_q[c] <= new_lvl[c];
      end
      if (cmd_i.restore) begin
        for (int c = 0; c < NUM_CH; c++) tgt_q[c] <= sav_q[c];
        steps_q <= steps_i;
      end
      if (cmd_i.clr) begin
        for (int c = 0; c < NUM_CH; c++) begin
          cur_q[c] <= '0;
          tgt_q[c] <= '0;
        end
        steps_q <= '0;
      end
      if (cmd_i.snap) begin
        for (int c = 0; c < NUM_CH; c++) cur_q[c] <= tgt_q[c];
      end
      if (cmd_i.commit) begin
        cur_q[cmd_i.ch] <= cur_q[cmd_i.ch] + delta;
      end
      if (cmd_i.dec_steps) begin
        steps_q <= steps_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= diff[LEVEL_BITS];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[LEVEL_BITS-2:0], fits};
      rem_q <= fits ? rem_sub[STEPS_BITS-1:0] : rem_sh[STEPS_BITS-1:0];
    end
  end

  // Blend tile from the updated levels.
  always_comb begin
    draw_c = !(cur_q[0] == NEUTRAL_LEVEL && cur_q[1] == NEUTRAL_LEVEL &&
               cur_q[2] == NEUTRAL_LEVEL);
    sub_c  = draw_c && (cur_q[0] <= NEUTRAL_LEVEL);
    for (int c = 0; c < NUM_CH; c++) begin
      if (!draw_c) begin
        tile_c[c] = '0;
      end else if (!sub_c) begin
        tile_c[c] = TILE_BITS'(cur_q[c] - 1'b1);
      end else if (cur_q[c] == NEUTRAL_LEVEL) begin
        tile_c[c] = '0;
      end else begin
        tile_c[c] = ~cur_q[c][TILE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      draw_q <= draw_c;
      sub_q  <= sub_c;
      for (int c = 0; c < NUM_CH; c++) begin
        tile_q[c] <= tile_c[c];
        lvl_q[c]  <= cur_q[c][OUT_LVL_BITS-1:0];
      end
    end
  end

  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign draw_o        = draw_q;
  assign subtractive_o = sub_q;
  assign tile_red_o    = tile_q[0];
  assign tile_green_o  = tile_q[1];
  assign tile_blue_o   = tile_q[2];
  assign level_red_o   = lvl_q[0];
  assign level_green_o = lvl_q[1];
  assign level_blue_o  = lvl_q[2];

endmodule

/* hdl/screen_fade_blend_stepper_unit.sv */
// Screen fade blend stepper: top level joining the sequencer and the datapath.
//
// Input channel (in_valid_i / in_stall_o) takes one command item: a frame
// tick, a target load (with or without save), a restore of the saved target,
// or a reset of the fade state. Only a frame tick yields a result item on the
// output channel (out_valid_o / out_stall_i); other commands yield nothing.
// Load, restore and reset items take effect at the edge they are accepted,
// so those commands can follow each other every cycle.
// A frame tick with steps left runs three serial divisions, one per channel,
// through one shared restoring divider; each channel passes the start,
// divide and commit states, and the result is loaded once the output
// register is free. A tick with no steps left snaps the levels to the
// target and loads its result the same way. One item is in work at a
// time, so in_stall_o is high while a tick is computed.
// The result sits in an output register; new items are accepted while it
// waits, but a finished tick holds until the register is free.
// Reset clears all levels, the step count and the output valid.
module screen_fade_blend_stepper_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sfbs_pkg::CMD_BITS-1:0]       cmd_i,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_red_i,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_green_i,
  input  logic [sfbs_pkg::LEVEL_BITS-1:0]     new_blue_i,
  input  logic [sfbs_pkg::STEPS_BITS-1:0]     steps_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                draw_o,
  output logic                                subtractive_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_red_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_green_o,
  output logic [sfbs_pkg::TILE_BITS-1:0]      tile_blue_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_red_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_green_o,
  output logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_blue_o
);
  import sfbs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  sfbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  sfbs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .new_red_i     (new_red_i),
    .new_green_i   (new_green_i),
    .new_blue_i    (new_blue_i),
    .steps_i       (steps_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .draw_o        (draw_o),
    .subtractive_o (subtractive_o),
    .tile_red_o    (tile_red_o),
    .tile_green_o  (tile_green_o),
    .tile_blue_o   (tile_blue_o),
    .level_red_o   (level_red_o),
    .level_green_o (level_green_o),
    .level_blue_o  (level_blue_o)
  );

endmodule

/* hdl/sfbs_checker.sv */
// Port-level checker for the fade blend stepper, bound to the top level.
module sfbs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [sfbs_pkg::CMD_BITS-1:0]       cmd_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                draw_o,
  input logic                                subtractive_o,
  input logic [sfbs_pkg::TILE_BITS-1:0]      tile_red_o,
  input logic [sfbs_pkg::TILE_BITS-1:0]      tile_green_o,
  input logic [sfbs_pkg::TILE_BITS-1:0]      tile_blue_o,
  input logic [sfbs_pkg::OUT_LVL_BITS-1:0]   level_red_o
);
  import sfbs_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // An item that draws nothing carries a blank tile.
  a_no_draw_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_o |->
      !subtractive_o && tile_red_o == '0 && tile_green_o == '0 && tile_blue_o == '0)
    else $error("blank tile expected when nothing is drawn");

  // The blend mode follows the red level.
  a_add_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && draw_o && !subtractive_o |-> level_red_o > 9'h100)
    else $error("additive mode with red level not above neutral");

  a_sub_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && subtractive_o |-> draw_o && level_red_o <= 9'h100)
    else $error("subtractive mode with red level above neutral");

  // A tick is computed alone: after accepting one, the input side stalls.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_TICK |=> in_stall_o)
    else $error("input accepted while a tick is in work");

endmodule

bind screen_fade_blend_stepper_unit sfbs_checker u_sfbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cmd_i         (cmd_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .draw_o        (draw_o),
  .subtractive_o (subtractive_o),
  .tile_red_o    (tile_red_o),
  .tile_green_o  (tile_green_o),
  .tile_blue_o   (tile_blue_o),
  .level_red_o   (level_red_o)
);

/* test/screen_fade_blend_stepper_unit_tb.sv */
// Self-checking testbench for the screen fade blend stepper top level.
`timescale 1ns / 100ps

module screen_fade_blend_stepper_unit_tb;
  import sfbs_pkg::*;

  typedef struct packed {
    logic                    draw;
    logic                    subtractive;
    logic [TILE_BITS-1:0]    tile_red;
    logic [TILE_BITS-1:0]    tile_green;
    logic [TILE_BITS-1:0]    tile_blue;
    logic [OUT_LVL_BITS-1:0] level_red;
    logic [OUT_LVL_BITS-1:0] level_green;
    logic [OUT_LVL_BITS-1:0] level_blue;
  } blend_result_t;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 400;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = CMD_BITS'(CMD_RESET + 1);
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_BITS-1:0] cmd = CMD_TICK;
  logic [LEVEL_BITS-1:0] new_red = '0;
  logic [LEVEL_BITS-1:0] new_green = '0;
  logic [LEVEL_BITS-1:0] new_blue = '0;
  logic [STEPS_BITS-1:0] steps = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic draw;
  logic subtractive;
  logic [TILE_BITS-1:0] tile_red, tile_green, tile_blue;
  logic [OUT_LVL_BITS-1:0] level_red, level_green, level_blue;

  // Own copy of the fade state.
  logic [LEVEL_BITS-1:0] fade_cur [NUM_CH];
  logic [LEVEL_BITS-1:0] fade_tgt [NUM_CH];
  logic [LEVEL_BITS-1:0] fade_saved [NUM_CH];
  logic [STEPS_BITS-1:0] fade_steps_left;

  blend_result_t expected_blends[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int items_accepted = 0;
  int blends_checked = 0;

  screen_fade_blend_stepper_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .new_red_i    (new_red),
    .new_green_i  (new_green),
    .new_blue_i   (new_blue),
    .steps_i      (steps),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .draw_o       (draw),
    .subtractive_o(subtractive),
    .tile_red_o   (tile_red),
    .tile_green_o (tile_green),
    .tile_blue_o  (tile_blue),
    .level_red_o  (level_red),
    .level_green_o(level_green),
    .level_blue_o (level_blue)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Updates the fade state for one accepted item and queues the blend a tick yields.
  task automatic fade_apply(input logic [CMD_BITS-1:0] c, input logic [LEVEL_BITS-1:0] r,
                            input logic [LEVEL_BITS-1:0] g, input logic [LEVEL_BITS-1:0] b,
                            input logic [STEPS_BITS-1:0] s);
    logic [LEVEL_BITS-1:0] loaded [NUM_CH];
    logic [LEVEL_BITS-1:0] lvl;
    logic [TILE_BITS-1:0] tile [NUM_CH];
    int diff;
    logic paint;
    logic sub;
    blend_result_t res;
    loaded[0] = r;
    loaded[1] = g;
    loaded[2] = b;
    case (c)
      CMD_SET_SAVE, CMD_SET: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          fade_tgt[ch] = loaded[ch];
          if (c == CMD_SET_SAVE) fade_saved[ch] = loaded[ch];
        end
        fade_steps_left = s;
      end
      CMD_RESTORE: begin
        for (int ch = 0; ch < NUM_CH; ch++) fade_tgt[ch] = fade_saved[ch];
        fade_steps_left = s;
      end
      CMD_RESET: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          fade_cur[ch] = '0;
          fade_tgt[ch] = '0;
        end
        fade_steps_left = '0;
      end
      CMD_TICK: begin
        if (fade_steps_left != 0) begin
          // Integer division truncates toward zero, as the step rule needs.
          for (int ch = 0; ch < NUM_CH; ch++) begin
            diff = int'(fade_tgt[ch]) - int'(fade_cur[ch]);
            fade_cur[ch] = LEVEL_BITS'(int'(fade_cur[ch]) + diff / int'(fade_steps_left));
          end
          fade_steps_left = fade_steps_left - 1'b1;
        end else begin
          for (int ch = 0; ch < NUM_CH; ch++) fade_cur[ch] = fade_tgt[ch];
        end
        paint = !(fade_cur[0] == NEUTRAL_LEVEL && fade_cur[1] == NEUTRAL_LEVEL &&
                  fade_cur[2] == NEUTRAL_LEVEL);
        sub = paint && (fade_cur[0] <= NEUTRAL_LEVEL);
        for (int ch = 0; ch < NUM_CH; ch++) begin
          lvl = fade_cur[ch];
          if (!paint) tile[ch] = '0;
          else if (!sub) tile[ch] = TILE_BITS'(lvl - 1'b1);
          else if (lvl == NEUTRAL_LEVEL) tile[ch] = '0;
          else tile[ch] = ~lvl[TILE_BITS-1:0];
        end
        res.draw = paint;
        res.subtractive = sub;
        res.tile_red = tile[0];
        res.tile_green = tile[1];
        res.tile_blue = tile[2];
        res.level_red = OUT_LVL_BITS'(fade_cur[0]);
        res.level_green = OUT_LVL_BITS'(fade_cur[1]);
        res.level_blue = OUT_LVL_BITS'(fade_cur[2]);
        expected_blends.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Offers one item, after a random gap, and holds it until it is accepted.
  task automatic send_item(input logic [CMD_BITS-1:0] c, input logic [LEVEL_BITS-1:0] r,
                           input logic [LEVEL_BITS-1:0] g, input logic [LEVEL_BITS-1:0] b,
                           input logic [STEPS_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    new_red <= r;
    new_green <= g;
    new_blue <= b;
    steps <= s;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    items_accepted++;
    fade_apply(c, r, g, b, s);
  endtask

  task automatic tick();
    send_item(CMD_TICK, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
              STEPS_BITS'($urandom));
  endtask

  task automatic wait_for_blends();
    in_valid <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LEVEL_BITS-1:0] pick_level();
    case ($urandom_range(9))
      0: return NEUTRAL_LEVEL;
      1: return NEUTRAL_LEVEL + 1'b1;
      2: return NEUTRAL_LEVEL - 1'b1;
      3: return '0;
      4: return '1;
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [STEPS_BITS-1:0] pick_steps();
    if ($urandom_range(19) == 0) return STEPS_BITS'($urandom);
    return STEPS_BITS'($urandom_range(6));
  endfunction

  task automatic test_after_reset();
    tick();
    tick();
  endtask

  task automatic test_jump_and_neutral();
    // All channels neutral with no steps: the next tick jumps there and draws nothing.
    send_item(CMD_SET, NEUTRAL_LEVEL, NEUTRAL_LEVEL, NEUTRAL_LEVEL, '0);
    tick();
    // Additive, with one channel at zero and one neutral.
    send_item(CMD_SET, '1, '0, NEUTRAL_LEVEL, '0);
    tick();
    // Subtractive with one neutral channel, and the additive threshold itself.
    send_item(CMD_SET, NEUTRAL_LEVEL - 1'b1, NEUTRAL_LEVEL, '0, '0);
    tick();
    send_item(CMD_SET, NEUTRAL_LEVEL + 1'b1, NEUTRAL_LEVEL + 1'b1, '1, '0);
    tick();
  endtask

  task automatic test_fade_steps();
    send_item(CMD_SET, '0, 9'h0AB, '1, 8'd3);
    repeat (4) tick();
    send_item(CMD_SET, '1, '0, NEUTRAL_LEVEL, '1);
    repeat (3) tick();
  endtask

  task automatic test_save_restore();
    send_item(CMD_SET_SAVE, 9'h155, 9'h0AA, NEUTRAL_LEVEL, 8'd2);
    send_item(CMD_SET, '0, '0, '0, 8'd1);
    send_item(CMD_RESTORE, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
              LEVEL_BITS'($urandom), 8'd2);
    repeat (3) tick();
  endtask

  task automatic test_reset_and_unknown();
    send_item(CMD_RESET, '1, '1, '1, '1);
    tick();
    for (int k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++) begin
      send_item(CMD_BITS'(k), LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
                LEVEL_BITS'($urandom), STEPS_BITS'($urandom));
    end
    tick();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    int done;
    int pick;
    logic [CMD_BITS-1:0] c;
    logic [LEVEL_BITS-1:0] r, g, b;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 58) c = CMD_TICK;
      else if (pick < 70) c = CMD_SET_SAVE;
      else if (pick < 82) c = CMD_SET;
      else if (pick < 91) c = CMD_RESTORE;
      else if (pick < 96) c = CMD_RESET;
      else c = CMD_BITS'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      if ($urandom_range(9) == 0) begin
        r = NEUTRAL_LEVEL;
        g = NEUTRAL_LEVEL;
        b = NEUTRAL_LEVEL;
      end else begin
        r = pick_level();
        g = pick_level();
        b = pick_level();
      end
      send_item(c, r, g, b, pick_steps());
      if (c <= CMD_RESET) done++;
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(CMD_SET, '1, '0, 9'h0C3, 8'd50);
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (20) tick();
    // Sender pauses here until every blend has come out.
    wait_for_blends();
    send_item(CMD_SET, NEUTRAL_LEVEL, '0, '1, 8'd4);
    repeat (5) tick();
    wait_for_blends();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Receiver stall, with an optional long hold-off counted down here.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_blends
    blend_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blends.size() == 0) begin
        $error("blend result with no item waiting for it");
        errors++;
      end else begin
        want = expected_blends.pop_front();
        blends_checked++;
        check_field("draw", want.draw, draw);
        check_field("subtractive", want.subtractive, subtractive);
        check_field("tile_red", want.tile_red, tile_red);
        check_field("tile_green", want.tile_green, tile_green);
        check_field("tile_blue", want.tile_blue, tile_blue);
        check_field("level_red", want.level_red, level_red);
        check_field("level_green", want.level_green, level_green);
        check_field("level_blue", want.level_blue, level_blue);
      end
    end
  end

  initial begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      fade_cur[ch] = '0;
      fade_tgt[ch] = '0;
      fade_saved[ch] = '0;
    end
    fade_steps_left = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_jump_and_neutral();
    test_fade_steps();
    test_save_restore();
    test_reset_and_unknown();
    wait_for_blends();

    test_random_phase(0, 0, RANDOM_PER_PHASE);
    test_random_phase(81, 0, RANDOM_PER_PHASE);
    test_random_phase(0, 81, RANDOM_PER_PHASE);
    test_random_phase(16, 16, RANDOM_PER_PHASE);
    wait_for_blends();
    test_backpressure();

    recv_stall_pct = 0;
    wait_for_blends();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_blends.size() != 0) begin
      $error("%0d blend results never arrived", expected_blends.size());
      errors++;
    end

    $display("Ran %0d items and checked %0d blend results over four idling mixes,",
             items_accepted, blends_checked);
    $display("a long output hold-off and a full drain, with %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
